>>> sv/ces_pkg.sv
// Shared constants, codes and types of the cross-window edge sharpener.
`timescale 1ns / 1ps

package ces_pkg;

	localparam int LUMA_BITS = 8;
	localparam int PIX_W = LUMA_BITS;
	localparam int TAPS = 5;
	localparam int SLOTS = 4;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int MAX_ROWS = 4096;
	localparam int ROW_W = 12;
	localparam int GEOM_W = 13;
	localparam int MIN_DIM = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int RESET_WIDTH = 1920;
	localparam int RESET_HEIGHT = 1080;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_STRENGTH = 3'd1,
		REG_WHITE_BOOST = 3'd2,
		REG_BLACK_BOOST = 3'd3,
		REG_FRAME_WIDTH = 3'd4,
		REG_FRAME_HEIGHT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0] threshold;
		logic signed [5:0] strength;
		logic [4:0] white_boost;
		logic [4:0] black_boost;
		logic [GEOM_W-1:0] frame_width;
		logic [GEOM_W-1:0] frame_height;
	} cfg_t;

	// One column of five vertical samples, oldest row in tap 0, plus the
	// emission, border and last-of-frame decisions taken by the front end.
	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] taps;
		logic emit;
		logic border;
		logic last;
	} item_t;

endpackage

>>> sv/ces_if.sv
// Stream interfaces for the input and output words of the sharpener.
`timescale 1ns / 1ps

interface ces_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [ces_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output command, output pixel, input ready);
	modport sink (input valid, input command, input pixel, output ready);
endinterface

interface ces_out_if;
	logic valid;
	logic ready;
	logic [ces_pkg::PIX_W-1:0] out_pixel;
	logic last_of_frame;

	modport source (output valid, output out_pixel, output last_of_frame, input ready);
	modport sink (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

>>> sv/cross_window_edge_sharpener.sv
// Top level of the cross-window edge sharpener: configuration, front end, queue, back end.
//
//   channel   direction   word
//   pix_in    sink        command (pixel or drain), pixel
//   pix_out   source      out_pixel, last_of_frame
//   cfg       write only  cfg_we, cfg_index, cfg_data
//
// The block takes one word per clock when the output side keeps up; the
// sustained rate is set by the line-store RAMs, each read once per word.
// The edge that accepts a word also registers its RAM read; the column then
// passes the queue write, the window shift, two arithmetic stages and the
// output register. Reset is asynchronous and acts on counters, queue, valid
// flags and the configuration registers only; the line stores are not cleared.
// A stall on pix_out holds the filter stages, and pix_in keeps taking words
// until the four-entry queue is full.
`timescale 1ns / 1ps

module cross_window_edge_sharpener #(
	parameter int MAX_WIDTH = ces_pkg::DEF_MAX_WIDTH
) (
	input logic clk,
	input logic arst_n,
	ces_in_if.sink pix_in,
	ces_out_if.source pix_out,
	input logic cfg_we,
	input logic [ces_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ces_pkg::CFG_DATA_W-1:0] cfg_data
);

	ces_pkg::cfg_t cfg_q;
	ces_pkg::item_t q_in;
	ces_pkg::item_t q_out;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic [ces_pkg::LEVEL_W-1:0] q_level;

	// Register file. Writes must arrive only while the block is idle; the block does
	// not enforce this. Both halves read the registers directly without any shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= '0;
			cfg_q.strength <= '0;
			cfg_q.white_boost <= '0;
			cfg_q.black_boost <= '0;
			cfg_q.frame_width <= ces_pkg::GEOM_W'(ces_pkg::RESET_WIDTH);
			cfg_q.frame_height <= ces_pkg::GEOM_W'(ces_pkg::RESET_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ces_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data[7:0];
				ces_pkg::REG_STRENGTH: cfg_q.strength <= $signed(cfg_data[5:0]);
				ces_pkg::REG_WHITE_BOOST: cfg_q.white_boost <= cfg_data[4:0];
				ces_pkg::REG_BLACK_BOOST: cfg_q.black_boost <= cfg_data[4:0];
				ces_pkg::REG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data;
				ces_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end keeps the raster counters and the four line stores. For
	// every word that has an effect it fetches one column of five samples
	// and decides whether an output falls due and whether it is a border.
	ces_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in),
		.cfg(cfg_q),
		.q_level(q_level),
		.push(q_push),
		.item(q_in)
	);

	// The queue lets the front end run on while the output side is stalled.
	ces_fifo u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_in),
		.pop(q_pop),
		.rdata(q_out),
		.empty(q_empty),
		.level(q_level)
	);

	// The back end slides the five columns along and computes the result.
	ces_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_item(q_out),
		.pop(q_pop),
		.pix_out(pix_out)
	);

`ifndef SYNTHESIS
	// The credit check on pix_in must keep the queue from overflowing.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && !q_pop && (q_level == ces_pkg::LEVEL_W'(ces_pkg::QUEUE_DEPTH))))
		else $error("queue pushed while full");

	// Input back-pressure only ever comes from work already in flight.
	a_ready_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> ((q_level != '0) || q_push))
		else $error("pix_in stalled with nothing queued");

	// A column only enters the queue in the cycle after a word was taken.
	a_push_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> $past(pix_in.valid && pix_in.ready))
		else $error("queue push without an accepted word");
`endif

endmodule

>>> sv/ces_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ces_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents when both ports hit the same address.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

>>> sv/ces_fifo.sv
// Short queue between the front end and the filter back end.
`timescale 1ns / 1ps

module ces_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ces_pkg::item_t wdata,
	input logic pop,
	output ces_pkg::item_t rdata,
	output logic empty,
	output logic [ces_pkg::LEVEL_W-1:0] level
);

	localparam int PW = $clog2(ces_pkg::QUEUE_DEPTH);

	ces_pkg::item_t mem_q [ces_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [ces_pkg::LEVEL_W-1:0] level_q;

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> sv/ces_front.sv
// Front end: accepts words, keeps raster counters and line stores, fetches columns.
`timescale 1ns / 1ps

module ces_front #(
	parameter int MAX_WIDTH = ces_pkg::DEF_MAX_WIDTH
) (
	input logic clk,
	input logic arst_n,
	ces_in_if.sink pix_in,
	input ces_pkg::cfg_t cfg,
	input logic [ces_pkg::LEVEL_W-1:0] q_level,
	output logic push,
	output ces_pkg::item_t item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = ces_pkg::ROW_W;
	localparam int HW = ces_pkg::GEOM_W;
	localparam int SW = $clog2(ces_pkg::SLOTS);
	localparam int PW = ces_pkg::PIX_W;

	logic [WW-1:0] w_used;
	logic [WW:0] w_ext;
	logic [HW-1:0] h_used;

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic acc;
	logic is_drain;
	logic tail;
	logic act;
	logic pixel_go;
	logic emit_pix;
	logic do_emit;
	logic in_col_end;
	logic in_row_end;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic c0_end;
	logic r0_end;
	logic border;
	logic [WW:0] oc2;
	logic wrap;
	logic [CW-1:0] rd_col;
	logic [SW-1:0] rd_slot;
	logic [PW-1:0] rd_data [ces_pkg::SLOTS];

	logic f1_valid_q;
	logic emit_s1;
	logic border_s1;
	logic last_s1;
	logic [PW-1:0] pixel_s1;
	logic [SW-1:0] slot_s1;

	// Geometry in use, saturated to its legal range.
	always_comb begin
		if (cfg.frame_width < HW'(ces_pkg::MIN_DIM)) begin
			w_used = WW'(ces_pkg::MIN_DIM);
		end else if ({1'b0, cfg.frame_width} > (HW + 1)'(MAX_WIDTH)) begin
			w_used = WW'(MAX_WIDTH);
		end else begin
			w_used = WW'(cfg.frame_width);
		end
		if (cfg.frame_height < HW'(ces_pkg::MIN_DIM)) begin
			h_used = HW'(ces_pkg::MIN_DIM);
		end else if (cfg.frame_height > HW'(ces_pkg::MAX_ROWS)) begin
			h_used = HW'(ces_pkg::MAX_ROWS);
		end else begin
			h_used = cfg.frame_height;
		end
	end

	assign w_ext = {1'b0, w_used};

	assign pix_in.ready = ({1'b0, q_level} + (ces_pkg::LEVEL_W + 1)'(f1_valid_q))
		< (ces_pkg::LEVEL_W + 1)'(ces_pkg::QUEUE_DEPTH);

	always_comb begin
		acc = pix_in.valid && pix_in.ready;
		is_drain = (pix_in.command == ces_pkg::CMD_DRAIN);
		tail = (in_row_q == '0) && (in_col_q == '0) && ((out_row_q != '0) || (out_col_q != '0));
		act = acc && (!is_drain || tail);
		pixel_go = acc && !is_drain;
		emit_pix = (in_row_q > RW'(2)) || ((in_row_q == RW'(2)) && (in_col_q >= CW'(2)));
		do_emit = act && (is_drain || emit_pix);

		in_col_end = ((WW + 1)'(in_col_q) + 1'b1) >= w_ext;
		in_row_end = (HW'(in_row_q) + 1'b1) >= h_used;

		// A new frame that starts over a pending tail restarts the output side.
		r0 = (pixel_go && tail) ? '0 : out_row_q;
		c0 = (pixel_go && tail) ? '0 : out_col_q;
		c0_end = ((WW + 1)'(c0) + 1'b1) >= w_ext;
		r0_end = (HW'(r0) + 1'b1) >= h_used;
		border = (r0 < RW'(2)) || ((HW'(r0) + HW'(3)) > h_used)
			|| (c0 < CW'(2)) || (((WW + 1)'(c0) + (WW + 1)'(3)) > w_ext);

		// Drains fetch the column two rows and two pixels ahead of the output.
		oc2 = (WW + 1)'(out_col_q) + (WW + 1)'(2);
		wrap = oc2 >= w_ext;
		if (is_drain) begin
			rd_col = wrap ? CW'(oc2 - w_ext) : CW'(oc2);
			rd_slot = out_row_q[SW-1:0] + (wrap ? SW'(3) : SW'(2));
		end else begin
			rd_col = in_col_q;
			rd_slot = in_row_q[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			f1_valid_q <= 1'b0;
		end else begin
			f1_valid_q <= act;
			if (pixel_go) begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_end ? '0 : RW'(in_row_q + 1'b1);
				end else begin
					in_col_q <= CW'(in_col_q + 1'b1);
				end
			end
			if (do_emit) begin
				if (c0_end) begin
					out_col_q <= '0;
					out_row_q <= r0_end ? '0 : RW'(r0 + 1'b1);
				end else begin
					out_col_q <= CW'(c0 + 1'b1);
					out_row_q <= r0;
				end
			end else if (pixel_go && tail) begin
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			emit_s1 <= is_drain || emit_pix;
			border_s1 <= border;
			last_s1 <= r0_end && c0_end;
			pixel_s1 <= pix_in.pixel;
			slot_s1 <= rd_slot;
		end
	end

	for (genvar g = 0; g < ces_pkg::SLOTS; g++) begin : g_slot
		ces_ram #(
			.WIDTH(PW),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk(clk),
			.we(pixel_go && (in_row_q[SW-1:0] == SW'(g))),
			.waddr(in_col_q),
			.wdata(pix_in.pixel),
			.raddr(rd_col),
			.rdata(rd_data[g])
		);
	end

	// The slot read at the fetch row holds the row four above it.
	always_comb begin
		for (int k = 0; k < ces_pkg::SLOTS; k++) begin
			item.taps[k] = rd_data[SW'(slot_s1 + SW'(k))];
		end
		item.taps[ces_pkg::TAPS-1] = pixel_s1;
		item.emit = emit_s1;
		item.border = border_s1;
		item.last = last_s1;
	end

	assign push = f1_valid_q;

endmodule

>>> sv/ces_back.sv
// Back end: five-column window, min/max selection, sharpening and clamp.
`timescale 1ns / 1ps

module ces_back (
	input logic clk,
	input logic arst_n,
	input ces_pkg::cfg_t cfg,
	input logic q_empty,
	input ces_pkg::item_t q_item,
	output logic pop,
	ces_out_if.source pix_out
);

	localparam int PW = ces_pkg::PIX_W;
	localparam int NT = ces_pkg::TAPS;
	localparam int AW = ces_pkg::LUMA_BITS + 3;
	localparam int MW = 16;
	localparam int THR_SHIFT = 16 - ces_pkg::LUMA_BITS;
	localparam logic signed [AW-1:0] PIX_MAX = AW'((1 << ces_pkg::LUMA_BITS) - 1);

	logic adv;

	logic [NT-1:0][NT-1:0][PW-1:0] hist_q;
	logic v_s1;
	logic border_s1;
	logic last_s1;

	logic [PW-1:0] vmn, vmx, hmn, hmx, mn, mx;
	logic v_s2;
	logic keep_s2;
	logic last_s2;
	logic [PW-1:0] src_s2, mn_s2, mx_s2;

	logic [PW:0] sum;
	logic [PW-1:0] avg;
	logic [PW-1:0] spread;
	logic [14:0] thr;
	logic signed [PW+1:0] diff;
	logic [AW-1:0] wc, bc, hboost, lboost, hi_raw, hi, lo;
	logic v_s3;
	logic keep_s3;
	logic last_s3;
	logic [PW-1:0] src_s3;
	logic signed [MW-1:0] prod_s3;
	logic [AW-1:0] hi_s3, lo_s3;

	logic signed [MW-1:0] delta;
	logic signed [AW-1:0] val;
	logic [AW-1:0] val_sat, res;
	logic o_valid_q;
	logic o_last_q;
	logic [PW-1:0] o_pix_q;

	assign adv = !o_valid_q || pix_out.ready;
	assign pop = adv && !q_empty;

	// Stage 2: vertical and horizontal extremes around the centre column.
	always_comb begin
		vmn = hist_q[2][0];
		vmx = hist_q[2][0];
		hmn = hist_q[0][2];
		hmx = hist_q[0][2];
		for (int i = 1; i < NT; i++) begin
			if (hist_q[2][i] < vmn) vmn = hist_q[2][i];
			if (hist_q[2][i] > vmx) vmx = hist_q[2][i];
			if (hist_q[i][2] < hmn) hmn = hist_q[i][2];
			if (hist_q[i][2] > hmx) hmx = hist_q[i][2];
		end
		if (PW'(vmx - vmn) > PW'(hmx - hmn)) begin
			mn = vmn;
			mx = vmx;
		end else begin
			mn = hmn;
			mx = hmx;
		end
	end

	// Stage 3: average, threshold, gain product and clamp bounds.
	always_comb begin
		sum = {1'b0, mx_s2} + {1'b0, mn_s2} + (PW + 1)'(1);
		avg = sum[PW:1];
		spread = mx_s2 - mn_s2;
		thr = {cfg.threshold, 7'b0} >> THR_SHIFT;
		diff = $signed({2'b0, src_s2}) - $signed({2'b0, avg});
		wc = AW'(cfg.white_boost) << (ces_pkg::LUMA_BITS - 8);
		bc = AW'(cfg.black_boost) << (ces_pkg::LUMA_BITS - 8);
		hboost = (src_s2 == mx_s2) ? AW'(wc << 1) : wc;
		lboost = (src_s2 == mn_s2) ? AW'(bc << 1) : bc;
		hi_raw = AW'(mx_s2) + hboost;
		hi = (hi_raw > AW'(PIX_MAX)) ? AW'(PIX_MAX) : hi_raw;
		lo = (lboost >= AW'(mn_s2)) ? '0 : AW'(mn_s2) - lboost;
	end

	// Stage 4: floored shift of the product, saturation and clamp, or the unchanged source for kept pixels.
	always_comb begin
		delta = prod_s3 >>> 4;
		val = $signed(AW'(src_s3)) + AW'(delta);
		if (val < 0) begin
			val_sat = '0;
		end else if (val > PIX_MAX) begin
			val_sat = AW'(PIX_MAX);
		end else begin
			val_sat = AW'(val);
		end
		if (keep_s3) begin
			res = AW'(src_s3);
		end else if (val_sat > hi_s3) begin
			res = hi_s3;
		end else if (val_sat < lo_s3) begin
			res = lo_s3;
		end else begin
			res = val_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			o_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && q_item.emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			o_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hist_q <= {hist_q[NT-2:0], q_item.taps};
			border_s1 <= q_item.border;
			last_s1 <= q_item.last;
		end
		if (adv) begin
			src_s2 <= hist_q[2][2];
			mn_s2 <= mn;
			mx_s2 <= mx;
			keep_s2 <= border_s1;
			last_s2 <= last_s1;

			src_s3 <= src_s2;
			prod_s3 <= MW'(diff) * MW'(cfg.strength);
			hi_s3 <= hi;
			lo_s3 <= lo;
			keep_s3 <= keep_s2 || ({7'b0, spread} <= thr);
			last_s3 <= last_s2;

			o_pix_q <= res[PW-1:0];
			o_last_q <= last_s3;
		end
	end

	assign pix_out.valid = o_valid_q;
	assign pix_out.out_pixel = o_pix_q;
	assign pix_out.last_of_frame = o_last_q;

endmodule

>>> verif/tb_cross_window_edge_sharpener.sv
// Self-checking testbench for the cross-window edge sharpener.
`timescale 1ns / 1ps

module tb_cross_window_edge_sharpener;
	import ces_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_WORDS = 1000;

	// The scoreboard keeps its own copy of the line stores, the row window,
	// the raster counters and the registers. Every accepted input word is
	// pushed through that copy, and the output word it causes, if any, is
	// queued for comparison with what the block later delivers.
	class sharpen_scoreboard;
		localparam int LINE_LEN = 4096;
		localparam int DEPTH = 8;
		localparam int PEAK = (1 << DEPTH) - 1;

		typedef struct packed {
			bit [7:0] px;
			bit last;
		} result_t;

		bit [7:0] lines[4 * LINE_LEN];
		bit [7:0] row_win[5];
		int unsigned in_col, in_row, out_col, out_row;
		bit [7:0] thr_level;
		bit signed [5:0] gain;
		bit [4:0] white_lift, black_drop;
		bit [12:0] width_reg, height_reg;
		result_t expected_q[$];

		function new();
			foreach (lines[i]) lines[i] = '0;
			foreach (row_win[i]) row_win[i] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			thr_level = '0;
			gain = '0;
			white_lift = '0;
			black_drop = '0;
			width_reg = 13'd1920;
			height_reg = 13'd1080;
		endfunction

		function void write_reg(reg_index_t idx, bit [12:0] d);
			case (idx)
				REG_THRESHOLD: thr_level = d[7:0];
				REG_STRENGTH: gain = d[5:0];
				REG_WHITE_BOOST: white_lift = d[4:0];
				REG_BLACK_BOOST: black_drop = d[4:0];
				REG_FRAME_WIDTH: width_reg = d;
				REG_FRAME_HEIGHT: height_reg = d;
				default: ;
			endcase
		endfunction

		function int unsigned line_rd(int unsigned y, int unsigned x);
			if (x >= LINE_LEN)
				return 0;
			return lines[(y & 3) * LINE_LEN + x];
		endfunction

		function void line_wr(int unsigned y, int unsigned x, bit [7:0] v);
			if (x < LINE_LEN)
				lines[(y & 3) * LINE_LEN + x] = v;
		endfunction

		function int unsigned sharpen_pixel(int unsigned w, int unsigned h);
			int unsigned r, c, src, vmn, vmx, hmn, hmx, mn, mx, avg, thr;
			int unsigned wc, bc, hi, lo, t;
			int prod, val;
			r = out_row;
			c = out_col;
			src = line_rd(r, c);
			if (r < 2 || r + 3 > h || c < 2 || c + 3 > w)
				return src;
			vmn = src;
			vmx = src;
			hmn = src;
			hmx = src;
			for (int i = 0; i < 5; i++) begin
				case (i)
					0: t = line_rd(r - 2, c);
					1: t = line_rd(r - 1, c);
					2: t = src;
					3: t = line_rd(r + 1, c);
					default: t = row_win[2];
				endcase
				if (t < vmn) vmn = t;
				if (t > vmx) vmx = t;
				t = line_rd(r, c - 2 + i);
				if (t < hmn) hmn = t;
				if (t > hmx) hmx = t;
			end
			// The vertical pair wins only on a strictly larger spread.
			mn = hmn;
			mx = hmx;
			if (vmx - vmn > hmx - hmn) begin
				mn = vmn;
				mx = vmx;
			end
			thr = (int'(thr_level) << 7) >> (16 - DEPTH);
			if (mx - mn <= thr)
				return src;
			avg = (mx + mn + 1) >> 1;
			prod = (int'(src) - int'(avg)) * int'(gain);
			val = int'(src) + (prod >>> 4);
			if (val < 0) val = 0;
			if (val > PEAK) val = PEAK;
			wc = int'(white_lift) << (DEPTH - 8);
			bc = int'(black_drop) << (DEPTH - 8);
			hi = mx + ((src == mx) ? 2 * wc : wc);
			if (hi > PEAK) hi = PEAK;
			lo = (src == mn) ? 2 * bc : bc;
			lo = (lo >= mn) ? 0 : mn - lo;
			if (val > int'(hi)) return hi;
			if (val < int'(lo)) return lo;
			return val;
		endfunction

		function void emit_result(int unsigned w, int unsigned h);
			result_t res;
			res.px = 8'(sharpen_pixel(w, h));
			res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
			expected_q.push_back(res);
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
			end else begin
				out_col++;
			end
		endfunction

		function void note_word(bit cmd, bit [7:0] px);
			int unsigned w, h, r, c;
			bit tail;
			w = width_reg;
			if (w < MIN_DIM) w = MIN_DIM;
			if (w > LINE_LEN) w = LINE_LEN;
			h = height_reg;
			if (h < MIN_DIM) h = MIN_DIM;
			if (h > MAX_ROWS) h = MAX_ROWS;
			tail = (in_row == 0 && in_col == 0) && (out_row != 0 || out_col != 0);
			if (cmd == CMD_DRAIN) begin
				if (tail)
					emit_result(w, h);
				return;
			end
			if (tail) begin
				out_row = 0;
				out_col = 0;
			end
			for (int i = 0; i < 4; i++) row_win[i] = row_win[i + 1];
			row_win[4] = px;
			r = in_row;
			c = in_col;
			if (r > 2 || (r == 2 && c >= 2))
				emit_result(w, h);
			if (c >= 3) line_wr(r, c - 3, row_win[1]);
			if (c + 1 >= w) begin
				if (c >= 2) line_wr(r, c - 2, row_win[2]);
				if (c >= 1) line_wr(r, c - 1, row_win[3]);
				line_wr(r, c, row_win[4]);
				in_col = 0;
				in_row = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				in_col = c + 1;
			end
		endfunction

		// Returns an empty string when the word matches the oldest expectation.
		function string check_word(bit [7:0] px, bit last);
			result_t exp_res;
			if (expected_q.size() == 0)
				return $sformatf("unexpected word px=%0d last=%0b", px, last);
			exp_res = expected_q.pop_front();
			if (exp_res.px != px || exp_res.last != last)
				return $sformatf("px=%0d last=%0b, expected px=%0d last=%0b",
					px, last, exp_res.px, exp_res.last);
			return "";
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ces_in_if in_if();
	ces_out_if out_if();

	cross_window_edge_sharpener dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(in_if),
		.pix_out(out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sharpen_scoreboard sb;
	int unsigned cycles;
	int fails;
	int in_max_gap;
	int out_max_gap;
	// Geometry in force, already saturated, so that stimulus can lay out frames.
	int cur_w;
	int cur_h;
	int words_sent;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH cycle %0d: %s", cycles, msg);
		fails++;
	endtask

	// All sampling happens on the rising edge; the drivers only move on the
	// falling edge, so nothing here races against the stimulus.
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			cycles++;
			if (cfg_we)
				sb.write_reg(reg_index_t'(cfg_index), cfg_data);
			if (in_if.valid && in_if.ready)
				sb.note_word(in_if.command, in_if.pixel);
			if (out_if.valid && out_if.ready) begin
				msg = sb.check_word(out_if.out_pixel, out_if.last_of_frame);
				if (msg != "")
					report_mismatch(msg);
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// The receiver draws a fresh stall before every word; a zero stall keeps
	// ready high, so back-to-back words are taken when the gap limit is zero.
	initial begin
		int gap;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, out_max_gap);
			if (gap > 0) begin
				out_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (!(out_if.valid && out_if.ready));
			@(negedge clk);
		end
	end

	// Called on a falling edge; returns on the falling edge after acceptance.
	task automatic send_word(logic cmd, logic [7:0] px);
		int gap;
		gap = $urandom_range(0, in_max_gap);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.command <= cmd;
		in_if.pixel <= px;
		do @(posedge clk); while (!(in_if.valid && in_if.ready));
		@(negedge clk);
		words_sent++;
	endtask

	// Register writes wait for a falling edge both after raising the enable and after
	// dropping it, so that the enable never sees two assignments in one time step.
	task automatic set_reg(reg_index_t idx, int value);
		int unsigned v;
		v = value & 13'h1fff;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_FRAME_WIDTH)
			cur_w = (v < MIN_DIM) ? MIN_DIM : (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
		if (idx == REG_FRAME_HEIGHT)
			cur_h = (v < MIN_DIM) ? MIN_DIM : (v > MAX_ROWS) ? MAX_ROWS : v;
	endtask

	// Waits until every expected word has arrived, then lets the pipeline
	// settle so that a register write cannot land on work still in flight.
	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_pixel(int style, int x, int y);
		int v;
		case (style)
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(0, 1) ? 255 : 0;
			2: v = x * 23 + y * 11 + $urandom_range(0, 12) - 6;
			default: v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
				: 120 + $urandom_range(0, 8);
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	// One full frame of pixels, with the odd stray drain mid-frame when noise is set,
	// which the block must ignore, followed by the given number of drain words.
	task automatic run_frame(int drains, int style, bit noise);
		for (int y = 0; y < cur_h; y++) begin
			for (int x = 0; x < cur_w; x++) begin
				if (noise && (x != 0 || y != 0) && $urandom_range(0, 39) == 0)
					send_word(CMD_DRAIN, 8'($urandom_range(0, 255)));
				send_word(CMD_PIXEL, pick_pixel(style, x, y));
			end
		end
		repeat (drains) send_word(CMD_DRAIN, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int frames;
		sb = new();
		cycles = 0;
		fails = 0;
		words_sent = 0;
		in_max_gap = 5;
		out_max_gap = 5;
		cur_w = RESET_WIDTH;
		cur_h = RESET_HEIGHT;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.command = CMD_PIXEL;
		in_if.pixel = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a drain with nothing pending, a small frame of full-scale
		// pixels at the strongest positive gain, drained with extras.
		set_reg(REG_THRESHOLD, 0);
		set_reg(REG_STRENGTH, 31);
		set_reg(REG_WHITE_BOOST, 0);
		set_reg(REG_BLACK_BOOST, 0);
		set_reg(REG_FRAME_WIDTH, 6);
		set_reg(REG_FRAME_HEIGHT, 5);
		send_word(CMD_DRAIN, 8'hff);
		run_frame(2 * cur_w + 4, 1, 1'b0);
		wait_idle();

		// Directed: most negative gain, top threshold, full boosts, undersized
		// geometry. The first frame is only partly drained, so the next frame
		// must throw its tail away.
		set_reg(REG_STRENGTH, 6'h20);
		set_reg(REG_THRESHOLD, 255);
		set_reg(REG_WHITE_BOOST, 31);
		set_reg(REG_BLACK_BOOST, 31);
		set_reg(REG_FRAME_WIDTH, 0);
		set_reg(REG_FRAME_HEIGHT, 4);
		run_frame(3, 1, 1'b0);
		wait_idle();
		set_reg(REG_THRESHOLD, 0);
		run_frame(2 * cur_w + 2, 0, 1'b0);
		wait_idle();

		// Random phases: fresh settings, a few frames of structured or noisy
		// content, partial drains between frames and a full drain at the end.
		while (words_sent < RANDOM_WORDS) begin
			set_reg(REG_THRESHOLD, $urandom_range(0, 255) | ($urandom_range(0, 31) << 8));
			set_reg(REG_STRENGTH, $urandom_range(0, 63) | ($urandom_range(0, 127) << 6));
			set_reg(REG_WHITE_BOOST, $urandom_range(0, 255));
			set_reg(REG_BLACK_BOOST, $urandom_range(0, 255));
			set_reg(REG_FRAME_WIDTH,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12));
			set_reg(REG_FRAME_HEIGHT,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 8));
			in_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
			out_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if (f == frames - 1)
					run_frame(2 * cur_w + 2 + $urandom_range(0, 2),
						$urandom_range(0, 3), 1'b1);
				else
					run_frame($urandom_range(0, 2 * cur_w + 4), $urandom_range(0, 3), 1'b1);
			end
			wait_idle();
		end

		if (sb.pending() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
sv/ces_pkg.sv
sv/ces_if.sv
sv/ces_ram.sv
sv/ces_fifo.sv
sv/ces_front.sv
sv/ces_back.sv
sv/cross_window_edge_sharpener.sv
verif/tb_cross_window_edge_sharpener.sv
